// File: rtl/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// shared types, codes and helpers of the ray axis handle pick unit
// ----------------------------------------------------------------------------
package rhp_pkg;

  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [31:0] Q30_NEG_ONE = 32'hC000_0000;
  localparam logic [30:0] THR_RESET   = 31'd1074;

  // how the clamped line parameter is obtained
  localparam logic [1:0] T_ZERO = 2'd0;
  localparam logic [1:0] T_LEN  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;

  localparam logic [1:0] AXIS_NONE = 2'd0;

  // register index decode (paddr bit 2)
  localparam logic REG_THR = 1'b0;

  localparam int DIV_STAGES = 31;

  typedef struct packed {
    logic [2:0][31:0] dir;
    logic [2:0][32:0] r;
    logic [30:0]      len;
    logic [61:0]      tol2;
    logic [2:0]       skip;
    logic [2:0][1:0]  mode;
    logic [2:0][30:0] numd;
    logic [2:0][30:0] den;
  } fr_t;

  typedef struct packed {
    fr_t              f;
    logic [2:0][30:0] q;
  } dv_t;

  typedef struct packed {
    logic [2:0]       skip;
    logic [2:0][30:0] t;
    logic [2:0][63:0] dist2;
    logic [61:0]      tol2;
  } ds_t;

  // clamp a q2.30 direction component to [-1, 1]
  function automatic logic [31:0] sat_dir(input logic [31:0] x);
    logic [31:0] y;
    begin
      y = x;
      if ($signed(x) > $signed(Q30_ONE)) y = Q30_ONE;
      else if ($signed(x) < $signed(Q30_NEG_ONE)) y = Q30_NEG_ONE;
      sat_dir = y;
    end
  endfunction

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [31:0] div_step(input logic [30:0] rem, input logic nb,
                                           input logic [30:0] den);
    logic [31:0] tr;
    logic [31:0] df;
    begin
      tr = {rem, nb};
      df = tr - {1'b0, den};
      if (tr >= {1'b0, den}) div_step = {1'b1, df[30:0]};
      else div_step = {1'b0, tr[30:0]};
    end
  endfunction

endpackage

// File: rtl/rhp_front.sv
// ----------------------------------------------------------------------------
// rhp_front
// front pipeline: offsets, projections, determinants and clamp decision
// ----------------------------------------------------------------------------
module rhp_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [349:0] in_data,
  input  logic [30:0]  thr,
  output logic         out_valid,
  input  logic         out_ready,
  output rhp_pkg::fr_t out_data
);

  localparam int NS = 6;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] vin;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int j = NS - 2; j >= 0; j--) en[j] = !v[j] || en[j+1];
  end

  assign vin = {v[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < NS; j++) if (en[j]) v[j] <= vin[j];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  // stage 0: saturate direction, ray offset
  logic [2:0][31:0] s0_dir;
  logic [2:0][32:0] s0_r;
  logic [30:0]      s0_len;
  logic [30:0]      s0_tol;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s0_dir[i] <= rhp_pkg::sat_dir(in_data[96+32*i +: 32]);
        s0_r[i]   <= {in_data[32*i+31], in_data[32*i +: 32]}
                   - {in_data[192+32*i+31], in_data[192+32*i +: 32]};
      end
      s0_len <= in_data[318:288];
      s0_tol <= in_data[349:319];
    end
  end

  // stage 1: products
  logic [2:0][31:0] s1_dir;
  logic [2:0][32:0] s1_r;
  logic [30:0]      s1_len;
  logic [61:0]      s1_tol2;
  logic [2:0][64:0] s1_p;
  logic [2:0][63:0] s1_bb;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_p[i]  <= $signed(s0_dir[i]) * $signed(s0_r[i]);
        s1_bb[i] <= $signed(s0_dir[i]) * $signed(s0_dir[i]);
      end
      s1_dir  <= s0_dir;
      s1_r    <= s0_r;
      s1_len  <= s0_len;
      s1_tol2 <= s0_tol * s0_tol;
    end
  end

  // stage 2: projection of the offset, determinants
  logic [2:0][31:0] s2_dir;
  logic [2:0][32:0] s2_r;
  logic [30:0]      s2_len;
  logic [61:0]      s2_tol2;
  logic [34:0]      s2_d14;
  logic [2:0][30:0] s2_den;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_d14 <= {{2{s1_p[0][64]}}, s1_p[0][64:32]}
              + {{2{s1_p[1][64]}}, s1_p[1][64:32]}
              + {{2{s1_p[2][64]}}, s1_p[2][64:32]};
      for (int i = 0; i < 3; i++) s2_den[i] <= 31'h4000_0000 - s1_bb[i][60:30];
      s2_dir  <= s1_dir;
      s2_r    <= s1_r;
      s2_len  <= s1_len;
      s2_tol2 <= s1_tol2;
    end
  end

  // stage 3: b*d and length bound products
  logic [2:0][31:0] s3_dir;
  logic [2:0][32:0] s3_r;
  logic [30:0]      s3_len;
  logic [61:0]      s3_tol2;
  logic [2:0][30:0] s3_den;
  logic [2:0][66:0] s3_bd;
  logic [2:0][61:0] s3_lc;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_bd[i] <= $signed(s2_dir[i]) * $signed(s2_d14);
        s3_lc[i] <= s2_len * s2_den[i];
      end
      s3_dir  <= s2_dir;
      s3_r    <= s2_r;
      s3_len  <= s2_len;
      s3_tol2 <= s2_tol2;
      s3_den  <= s2_den;
    end
  end

  // stage 4: numerator, rounded-up bound, parallel test
  logic [2:0][31:0] s4_dir;
  logic [2:0][32:0] s4_r;
  logic [30:0]      s4_len;
  logic [61:0]      s4_tol2;
  logic [2:0][30:0] s4_den;
  logic [2:0][39:0] s4_num;
  logic [2:0][32:0] s4_c;
  logic [2:0]       s4_skip;
  logic [2:0][62:0] lc_up;

  always_comb begin
    for (int i = 0; i < 3; i++) lc_up[i] = {1'b0, s3_lc[i]} + 63'h3FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_num[i]  <= {{7{s3_r[i][32]}}, s3_r[i]} - {s3_bd[i][66], s3_bd[i][66:28]};
        s4_c[i]    <= lc_up[i][62:30];
        s4_skip[i] <= (s3_den[i] == '0) || (s3_den[i] < thr);
      end
      s4_dir  <= s3_dir;
      s4_r    <= s3_r;
      s4_len  <= s3_len;
      s4_tol2 <= s3_tol2;
      s4_den  <= s3_den;
    end
  end

  // stage 5: clamp decision
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        if ($signed(s4_num[i]) <= 0) out_data.mode[i] <= rhp_pkg::T_ZERO;
        else if (s4_num[i] >= {7'd0, s4_c[i]}) out_data.mode[i] <= rhp_pkg::T_LEN;
        else out_data.mode[i] <= rhp_pkg::T_DIV;
        out_data.numd[i] <= s4_num[i][30:0];
      end
      out_data.dir  <= s4_dir;
      out_data.r    <= s4_r;
      out_data.len  <= s4_len;
      out_data.tol2 <= s4_tol2;
      out_data.skip <= s4_skip;
      out_data.den  <= s4_den;
    end
  end

endmodule

// File: rtl/rhp_div.sv
// ----------------------------------------------------------------------------
// rhp_div
// pipelined restoring divider, one quotient bit per stage, three axes
// ----------------------------------------------------------------------------
module rhp_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rhp_pkg::fr_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output rhp_pkg::dv_t out_data
);

  localparam int NS = rhp_pkg::DIV_STAGES;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] vin;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int j = NS - 2; j >= 0; j--) en[j] = !v[j] || en[j+1];
  end

  assign vin = {v[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < NS; j++) if (en[j]) v[j] <= vin[j];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  rhp_pkg::fr_t     f_s   [NS];
  logic [2:0][30:0] rem_s [NS];
  logic [2:0][30:0] q_s   [NS];

  for (genvar j = 0; j < NS; j++) begin : g_st
    rhp_pkg::fr_t     fin;
    logic [2:0][30:0] rin;
    logic [2:0][30:0] qin;
    logic [2:0]       bin;
    logic [2:0][31:0] st;

    if (j == 0) begin : g_first
      // remainder starts at num >> 1, the low bit comes in first
      always_comb begin
        fin = in_data;
        qin = '0;
        for (int k = 0; k < 3; k++) begin
          rin[k] = {1'b0, in_data.numd[k][30:1]};
          bin[k] = in_data.numd[k][0];
        end
      end
    end else begin : g_next
      always_comb begin
        fin = f_s[j-1];
        rin = rem_s[j-1];
        qin = q_s[j-1];
        bin = '0;
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) st[k] = rhp_pkg::div_step(rin[k], bin[k], fin.den[k]);
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        f_s[j] <= fin;
        for (int k = 0; k < 3; k++) begin
          rem_s[j][k] <= st[k][30:0];
          q_s[j][k]   <= {qin[k][29:0], st[k][31]};
        end
      end
    end
  end

  assign out_data.f = f_s[NS-1];
  assign out_data.q = q_s[NS-1];

endmodule

// File: rtl/rhp_dist.sv
// ----------------------------------------------------------------------------
// rhp_dist
// distance pipeline: clamped point, ray projection, squared distance
// ----------------------------------------------------------------------------
module rhp_dist (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rhp_pkg::dv_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output rhp_pkg::ds_t out_data
);

  localparam int NS = 7;

  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] vin;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int j = NS - 2; j >= 0; j--) en[j] = !v[j] || en[j+1];
  end

  assign vin = {v[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < NS; j++) if (en[j]) v[j] <= vin[j];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  // stage 0: pick t, point relative to ray origin
  logic [2:0][31:0]      d0_dir;
  logic [2:0]            d0_skip;
  logic [2:0][30:0]      d0_t;
  logic [61:0]           d0_tol2;
  logic [2:0][2:0][34:0] d0_rel;
  logic [2:0][30:0]      t_sel;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (in_data.f.mode[k])
        rhp_pkg::T_ZERO: t_sel[k] = '0;
        rhp_pkg::T_LEN:  t_sel[k] = in_data.f.len;
        rhp_pkg::T_DIV:  t_sel[k] = in_data.q[k];
        default:         t_sel[k] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          d0_rel[k][i] <= 35'd0 - {{2{in_data.f.r[i][32]}}, in_data.f.r[i]}
                        + ((i == k) ? {4'd0, t_sel[k]} : 35'd0);
        end
      end
      d0_dir  <= in_data.f.dir;
      d0_skip <= in_data.f.skip;
      d0_t    <= t_sel;
      d0_tol2 <= in_data.f.tol2;
    end
  end

  // stage 1: rel * dir
  logic [2:0][31:0]      d1_dir;
  logic [2:0]            d1_skip;
  logic [2:0][30:0]      d1_t;
  logic [61:0]           d1_tol2;
  logic [2:0][2:0][34:0] d1_rel;
  logic [2:0][2:0][66:0] d1_prod;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++)
        for (int i = 0; i < 3; i++)
          d1_prod[k][i] <= $signed(d0_rel[k][i]) * $signed(d0_dir[i]);
      d1_dir  <= d0_dir;
      d1_skip <= d0_skip;
      d1_t    <= d0_t;
      d1_tol2 <= d0_tol2;
      d1_rel  <= d0_rel;
    end
  end

  // stage 2: ray parameter, clamped at zero
  logic [2:0][31:0]      d2_dir;
  logic [2:0]            d2_skip;
  logic [2:0][30:0]      d2_t;
  logic [61:0]           d2_tol2;
  logic [2:0][2:0][34:0] d2_rel;
  logic [2:0][35:0]      d2_s;
  logic [2:0][36:0]      s_sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_sum[k] = {{2{d1_prod[k][0][66]}}, d1_prod[k][0][66:32]}
               + {{2{d1_prod[k][1][66]}}, d1_prod[k][1][66:32]}
               + {{2{d1_prod[k][2][66]}}, d1_prod[k][2][66:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) d2_s[k] <= s_sum[k][36] ? 36'd0 : s_sum[k][35:0];
      d2_dir  <= d1_dir;
      d2_skip <= d1_skip;
      d2_t    <= d1_t;
      d2_tol2 <= d1_tol2;
      d2_rel  <= d1_rel;
    end
  end

  // stage 3: point on the ray
  logic [2:0]            d3_skip;
  logic [2:0][30:0]      d3_t;
  logic [61:0]           d3_tol2;
  logic [2:0][2:0][34:0] d3_rel;
  logic [2:0][2:0][68:0] d3_ds;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++)
        for (int i = 0; i < 3; i++)
          d3_ds[k][i] <= $signed(d2_dir[i]) * $signed({1'b0, d2_s[k]});
      d3_skip <= d2_skip;
      d3_t    <= d2_t;
      d3_tol2 <= d2_tol2;
      d3_rel  <= d2_rel;
    end
  end

  // stage 4: gap vector magnitude per component
  logic [2:0]            d4_skip;
  logic [2:0][30:0]      d4_t;
  logic [61:0]           d4_tol2;
  logic [2:0][2:0][31:0] d4_mag;
  logic [2:0][2:0]       d4_big;
  logic [2:0][2:0][41:0] w;
  logic [2:0][2:0][41:0] wm;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        w[k][i]  = {d3_ds[k][i][68], d3_ds[k][i][68:28]}
                 - {{7{d3_rel[k][i][34]}}, d3_rel[k][i]};
        wm[k][i] = w[k][i][41] ? 42'd0 - w[k][i] : w[k][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          d4_mag[k][i] <= wm[k][i][31:0];
          d4_big[k][i] <= |wm[k][i][41:32];
        end
      end
      d4_skip <= d3_skip;
      d4_t    <= d3_t;
      d4_tol2 <= d3_tol2;
    end
  end

  // stage 5: squares
  logic [2:0]            d5_skip;
  logic [2:0][30:0]      d5_t;
  logic [61:0]           d5_tol2;
  logic [2:0][2:0][63:0] d5_sq;
  logic [2:0]            d5_big;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) d5_sq[k][i] <= d4_mag[k][i] * d4_mag[k][i];
        d5_big[k] <= |d4_big[k];
      end
      d5_skip <= d4_skip;
      d5_t    <= d4_t;
      d5_tol2 <= d4_tol2;
    end
  end

  // stage 6: saturating sum of squares
  logic [2:0][64:0] sum_a;
  logic [2:0][64:0] sum_b;
  logic [2:0][63:0] dsum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_a[k] = {1'b0, d5_sq[k][0]} + {1'b0, d5_sq[k][1]};
      if (sum_a[k][64]) sum_a[k] = {1'b0, {64{1'b1}}};
      sum_b[k] = {1'b0, sum_a[k][63:0]} + {1'b0, d5_sq[k][2]};
      if (d5_big[k] || sum_b[k][64]) dsum[k] = '1;
      else dsum[k] = sum_b[k][63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      out_data.dist2 <= dsum;
      out_data.skip  <= d5_skip;
      out_data.t     <= d5_t;
      out_data.tol2  <= d5_tol2;
    end
  end

endmodule

// File: rtl/ray_axis_handle_pick_unit.sv
// ----------------------------------------------------------------------------
// ray_axis_handle_pick_unit
// picks the gizmo axis handle (x, y or z) closest to a ray, within tolerance
// ----------------------------------------------------------------------------
//
//  channel   dir  width  content
//  s_*       in   352    ray origin, ray direction, handle origin, length, tol
//  m_*       out  40     picked axis and clamped position along it
//  apb       in   32     parallel_threshold at byte address 0
//
//  from input accept to result valid an item passes through 6 front stages,
//  31 divider stages (one quotient bit each), 7 distance stages and 1 output register
//  one item per cycle sustained while m_tready stays high; every stage, the
//  divider included, takes a new item each cycle unless it is stalled
//  reset clears all valid bits and loads the threshold default (about 1e-6)
//  each stage holds while its successor is full and stalled, so bubbles
//  close up and s_tready stays high as long as any stage has room
//
module ray_axis_handle_pick_unit (
  input  logic         clk,
  input  logic         rst,
  // slave stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // from bit 0: ray_origin_x/y/z, ray_dir_x/y/z, handle_origin_x/y/z (32 each),
  // segment_length (31), pick_tolerance (31), zero pad (2)
  input  logic [351:0] s_tdata,
  // master stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // from bit 0: picked_axis (2), picked_param (31), zero pad (7)
  output logic [39:0]  m_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // parallel threshold register
  logic [30:0] thr;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rhp_pkg::REG_THR);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rhp_pkg::THR_RESET;
    end else if (cfg_wr) begin
      thr <= pwdata[30:0];
    end
  end

  assign prdata = (paddr[2] == rhp_pkg::REG_THR) ? {1'b0, thr} : 32'd0;

  // pipeline sections
  logic         fr_valid, fr_ready;
  rhp_pkg::fr_t fr_data;
  logic         dv_valid, dv_ready;
  rhp_pkg::dv_t dv_data;
  logic         ds_valid, ds_ready;
  rhp_pkg::ds_t ds_data;

  rhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata[349:0]),
    .thr       (thr),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  rhp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  rhp_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .out_valid (ds_valid),
    .out_ready (ds_ready),
    .out_data  (ds_data)
  );

  // pick: first strict minimum over x, y, z, then tolerance test
  logic        have;
  logic [63:0] best;
  logic [1:0]  best_axis;
  logic [30:0] best_t;
  logic [1:0]  axis_next;
  logic [30:0] param_next;

  always_comb begin
    have      = 1'b0;
    best      = '1;
    best_axis = rhp_pkg::AXIS_NONE;
    best_t    = '0;
    for (int k = 0; k < 3; k++) begin
      if (!ds_data.skip[k] && (!have || ds_data.dist2[k] < best)) begin
        have      = 1'b1;
        best      = ds_data.dist2[k];
        best_axis = 2'(k + 1);
        best_t    = ds_data.t[k];
      end
    end
    if (have && best <= {2'b00, ds_data.tol2}) begin
      axis_next  = best_axis;
      param_next = best_t;
    end else begin
      axis_next  = rhp_pkg::AXIS_NONE;
      param_next = '0;
    end
  end

  // output register
  logic        ov;
  logic [1:0]  axis_o;
  logic [30:0] param_o;

  assign ds_ready = !ov || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ds_ready) begin
      ov <= ds_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ds_ready) begin
      axis_o  <= axis_next;
      param_o <= param_next;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {7'd0, param_o, axis_o};

  // checks
  a_none_zero_param: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && axis_o == rhp_pkg::AXIS_NONE) |-> (param_o == 31'd0))
    else $error("no axis picked but position nonzero");

  a_thr_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (thr == $past(pwdata[30:0])))
    else $error("threshold write lost");

  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule
